// ===== rtl/core/bundle_header_parser_core_macros.svh =====
// assertion macros for the bundle header parser
`ifndef BUNDLE_HEADER_PARSER_CORE_MACROS_SVH
`define BUNDLE_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define BHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define BHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bhp_pkg.sv =====
// constants and result type for the bundle header parser
package bhp_pkg;

   localparam int unsigned HEADER_BYTES = 26;
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

   localparam logic [7:0] VERSION_WANTED = 8'd3;
   localparam int unsigned OFS_MAGIC   = 0;
   localparam int unsigned OFS_VERSION = 4;
   localparam int unsigned OFS_FLAGS   = 5;
   localparam int unsigned OFS_DEX     = 6;
   localparam int unsigned OFS_MARKER  = 9;
   localparam int unsigned OFS_KEY_ID  = 10;
   localparam int unsigned OFS_RECORDS = 12;
   localparam int unsigned OFS_TABLE   = 14;
   localparam int unsigned OFS_PAYLOAD = 18;

   localparam int unsigned CNT_W = 64;

   // first member lands in the highest bits, header_ok in bit 0
   typedef struct packed {
      logic [32:0] payload_start;
      logic [63:0] payload_length;
      logic [31:0] bridge_table_length;
      logic [15:0] bridge_records;
      logic [15:0] key_id_length;
      logic [23:0] dex_version;
      logic [7:0]  flags_byte;
      logic [7:0]  fmt_version;
      logic        header_ok;
   } rsp_type;

   localparam int unsigned RSP_BITS   = $bits(rsp_type);
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

endpackage

// ===== rtl/core/bundle_header_parser_core.sv =====
// bundle header parser: byte counter, header capture and verdict
// a final byte goes through the input register, then the result register, to rsp_tvalid
// throughput: one byte per cycle; a stalled result holds the next final byte and the intake
// the verdict path is one 65-bit length sum and compare behind the input register
// reset clears the byte counter, the magic register and all valid flags
// header bytes hold no reset and are always rewritten before a full bundle reads them
`include "bundle_header_parser_core_macros.svh"

module bundle_header_parser_core
   import bhp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data,    // magic_word
   // byte stream in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // last_byte
   // verdict out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // header_ok[0], fmt_version[8:1], flags_byte[16:9], dex_version[40:17],
   // key_id_length[56:41], bridge_records[72:57], bridge_table_length[104:73],
   // payload_length[168:105], payload_start[201:169], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [31:0]      magic_ff, magic_in;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_data_ff;
   logic             in_last_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       hdr_ff [HEADER_BYTES];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;

   logic             out_free;
   logic             s1_advance;
   logic             hdr_wr;
   logic [HDR_IDX_W-1:0] hdr_idx;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       hv [HEADER_BYTES];
   logic [15:0]      key_len;
   logic [15:0]      records;
   logic [31:0]      table_len;
   logic [63:0]      pay_len;
   logic [32:0]      pay_ofs;
   logic [64:0]      total;
   logic             full_hdr;
   logic             ok;
   rsp_type          rsp_in;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || s1_advance;

   always_comb begin
      magic_in = magic_ff;
      if (csr_valid && csr_ready) begin
         magic_in = csr_data;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   // saturating byte count including the byte in the input register
   assign cnt_inc = (&cnt_ff) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign hdr_wr  = s1_advance && (cnt_ff < CNT_W'(HEADER_BYTES));
   assign hdr_idx = cnt_ff[HDR_IDX_W-1:0];

   always_comb begin
      cnt_in = cnt_ff;
      if (s1_advance) begin
         cnt_in = in_last_ff ? '0 : cnt_inc;
      end
   end

   // header as it stands once the current byte is written
   always_comb begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hv[i] = (hdr_wr && hdr_idx == HDR_IDX_W'(i)) ? in_data_ff : hdr_ff[i];
      end
   end

   assign key_len   = {hv[OFS_KEY_ID+1], hv[OFS_KEY_ID]};
   assign records   = {hv[OFS_RECORDS+1], hv[OFS_RECORDS]};
   assign table_len = {hv[OFS_TABLE+3], hv[OFS_TABLE+2], hv[OFS_TABLE+1], hv[OFS_TABLE]};
   assign pay_len   = {hv[OFS_PAYLOAD+7], hv[OFS_PAYLOAD+6], hv[OFS_PAYLOAD+5],
                       hv[OFS_PAYLOAD+4], hv[OFS_PAYLOAD+3], hv[OFS_PAYLOAD+2],
                       hv[OFS_PAYLOAD+1], hv[OFS_PAYLOAD]};
   assign pay_ofs   = 33'(HEADER_BYTES) + {17'b0, key_len} + {1'b0, table_len};
   assign total     = {32'b0, pay_ofs} + {1'b0, pay_len};
   assign full_hdr  = cnt_inc >= CNT_W'(HEADER_BYTES);

   assign ok = full_hdr
      && ({hv[OFS_MAGIC+3], hv[OFS_MAGIC+2], hv[OFS_MAGIC+1], hv[OFS_MAGIC]} == magic_ff)
      && (hv[OFS_VERSION] == VERSION_WANTED)
      && (hv[OFS_MARKER] == 8'd0)
      && (total == {1'b0, cnt_inc});

   always_comb begin
      rsp_in = '0;
      if (full_hdr) begin
         rsp_in.fmt_version         = hv[OFS_VERSION];
         rsp_in.flags_byte          = hv[OFS_FLAGS];
         rsp_in.dex_version         = {hv[OFS_DEX+2], hv[OFS_DEX+1], hv[OFS_DEX]};
         rsp_in.key_id_length       = key_len;
         rsp_in.bridge_records      = records;
         rsp_in.bridge_table_length = table_len;
         rsp_in.payload_length      = pay_len;
         rsp_in.payload_start       = pay_ofs;
      end
      rsp_in.header_ok = ok;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= '0;
         in_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         magic_ff     <= magic_in;
         in_valid_ff  <= in_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (hdr_wr) begin
         hdr_ff[hdr_idx] <= in_data_ff;
      end
      if (s1_advance && in_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0), rsp_ff};

   `BHP_ASSERT_NEXT(a_rsp_from_last, clock, reset, !rsp_valid_ff,
      !rsp_valid_ff || $past(in_valid_ff && in_last_ff), "result without a final byte")
   `BHP_ASSERT_NEXT(a_cnt_clears, clock, reset, s1_advance && in_last_ff,
      cnt_ff == '0, "byte count not cleared after final byte")
   `BHP_ASSERT_NEXT(a_cnt_counts, clock, reset, s1_advance && !in_last_ff,
      cnt_ff != '0, "byte count did not advance")
   `BHP_ASSERT_NOW(a_ok_offset, clock, reset, rsp_valid_ff && rsp_ff.header_ok,
      rsp_ff.payload_start >= 33'(HEADER_BYTES), "pass with offset below header size")

endmodule
